/* hw/rtl/mmt_pkg.sv */
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types, request and source codes and Q2.14 clamps for the
// modulation matrix table.
// ----------------------------------------------------------------------------
package mmt_pkg;

	localparam int CNT_W = 5;
	localparam int ACC_W = 40;
	localparam int SUM_W = 42;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
	localparam logic signed [15:0] MINUS_ONE_Q14 = -16'sd16384;
	localparam logic signed [15:0] ZERO_Q14    = 16'sd0;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = 40'sd8192;
	localparam int FRAC_BITS = 14;

	localparam logic signed [SUM_W-1:0] SAT_MAX = 42'sd2147483647;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -42'sd2147483648;

	typedef enum logic [2:0] {
		REQ_ADD    = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_SETAMT = 3'd2,
		REQ_SETACT = 3'd3,
		REQ_CLEAR  = 3'd4,
		REQ_SETSRC = 3'd5,
		REQ_PROC   = 3'd6,
		REQ_READ   = 3'd7
	} req_t;

	localparam logic [3:0] SRC_LFO3    = 4'd2;
	localparam logic [3:0] SRC_ADSR1   = 4'd3;
	localparam logic [3:0] SRC_ADSR2   = 4'd4;
	localparam logic [3:0] SRC_VEL     = 4'd7;
	localparam logic [3:0] SRC_AFT     = 4'd8;
	localparam logic [3:0] SRC_WHEEL   = 4'd9;
	localparam logic [3:0] SRC_GATE    = 4'd10;
	localparam logic [3:0] SRC_PRESS   = 4'd12;
	localparam logic [3:0] SRC_INVALID = 4'd15;

	typedef struct packed {
		logic [3:0]         src;
		logic [3:0]         dest;
		logic signed [15:0] amount;
		logic               active;
	} conn_t;

	typedef struct packed {
		logic               use_it;
		logic signed [15:0] level;
	} lvl_t;

	function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v);
		logic signed [15:0] r;
		r = v;
		if (v < MINUS_ONE_Q14) begin
			r = MINUS_ONE_Q14;
		end else if (v > ONE_Q14) begin
			r = ONE_Q14;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_pos(input logic signed [15:0] v);
		logic signed [15:0] r;
		r = v;
		if (v < ZERO_Q14) begin
			r = ZERO_Q14;
		end else if (v > ONE_Q14) begin
			r = ONE_Q14;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/mmt_sources.sv */
// ----------------------------------------------------------------------------
// mmt_sources
// Source value registers: stores LFO, ADSR and performance levels and
// looks up the level of one source for the accumulate path.
// ----------------------------------------------------------------------------
module mmt_sources (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                set_en,
	input  logic [3:0]          set_src,
	input  logic signed [15:0]  set_val,
	output logic                set_ok,
	input  logic [3:0]          look_src,
	output mmt_pkg::lvl_t       look
);

	logic signed [15:0] lfo_q [3];
	logic signed [15:0] adsr_q [2];
	logic [2:0]         lfo_present_q;
	logic [1:0]         adsr_present_q;
	logic signed [15:0] vel_q;
	logic signed [15:0] aft_q;
	logic signed [15:0] wheel_q;
	logic signed [15:0] gate_q;
	logic signed [15:0] press_q;

	always_comb begin
		set_ok = (set_src <= mmt_pkg::SRC_ADSR2) || (set_src == mmt_pkg::SRC_VEL)
			|| (set_src == mmt_pkg::SRC_AFT) || (set_src == mmt_pkg::SRC_WHEEL)
			|| (set_src == mmt_pkg::SRC_GATE) || (set_src == mmt_pkg::SRC_PRESS);
	end

	always_ff @(posedge clk) begin
		if (set_en) begin
			if (set_src <= mmt_pkg::SRC_LFO3) begin
				lfo_q[set_src[1:0]] <= set_val;
			end else if (set_src == mmt_pkg::SRC_ADSR1) begin
				adsr_q[0] <= set_val;
			end else if (set_src == mmt_pkg::SRC_ADSR2) begin
				adsr_q[1] <= set_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_present_q  <= '0;
			adsr_present_q <= '0;
			vel_q          <= '0;
			aft_q          <= '0;
			wheel_q        <= '0;
			gate_q         <= '0;
			press_q        <= '0;
		end else if (set_en) begin
			if (set_src <= mmt_pkg::SRC_LFO3) begin
				lfo_present_q[set_src[1:0]] <= 1'b1;
			end else if (set_src == mmt_pkg::SRC_ADSR1) begin
				adsr_present_q[0] <= 1'b1;
			end else if (set_src == mmt_pkg::SRC_ADSR2) begin
				adsr_present_q[1] <= 1'b1;
			end else if (set_src == mmt_pkg::SRC_VEL) begin
				vel_q <= mmt_pkg::clamp_pos(set_val);
			end else if (set_src == mmt_pkg::SRC_AFT) begin
				aft_q <= mmt_pkg::clamp_pos(set_val);
			end else if (set_src == mmt_pkg::SRC_WHEEL) begin
				wheel_q <= mmt_pkg::clamp_sym(set_val);
			end else if (set_src == mmt_pkg::SRC_GATE) begin
				gate_q <= set_val;
			end else if (set_src == mmt_pkg::SRC_PRESS) begin
				press_q <= mmt_pkg::clamp_pos(set_val);
			end
		end
	end

	always_comb begin
		look.use_it = 1'b1;
		look.level  = '0;
		if (look_src <= mmt_pkg::SRC_LFO3) begin
			look.use_it = lfo_present_q[look_src[1:0]];
			look.level  = lfo_q[look_src[1:0]];
		end else if (look_src == mmt_pkg::SRC_ADSR1) begin
			look.use_it = adsr_present_q[0];
			look.level  = adsr_q[0];
		end else if (look_src == mmt_pkg::SRC_ADSR2) begin
			look.use_it = adsr_present_q[1];
			look.level  = adsr_q[1];
		end else if (look_src == mmt_pkg::SRC_VEL) begin
			look.level = vel_q;
		end else if (look_src == mmt_pkg::SRC_AFT) begin
			look.level = aft_q;
		end else if (look_src == mmt_pkg::SRC_WHEEL) begin
			look.level = wheel_q;
		end else if (look_src == mmt_pkg::SRC_GATE) begin
			look.level = gate_q;
		end else if (look_src == mmt_pkg::SRC_PRESS) begin
			look.level = press_q;
		end else if (look_src == mmt_pkg::SRC_INVALID) begin
			look.use_it = 1'b0;
		end
	end

endmodule

/* hw/rtl/mmt_mac.sv */
// ----------------------------------------------------------------------------
// mmt_mac
// Shared multiply-accumulate unit: registered 16x16 product followed by
// a wide accumulator, fed one table entry per cycle.
// ----------------------------------------------------------------------------
module mmt_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clr,
	input  logic                            en,
	input  logic signed [15:0]              a,
	input  logic signed [15:0]              b,
	output logic signed [mmt_pkg::ACC_W-1:0] acc
);

	logic signed [31:0]               prod_s2;
	logic                             prodv_s2;
	logic signed [mmt_pkg::ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prodv_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			prodv_s2 <= en;
			if (clr) begin
				acc_q <= '0;
			end else if (prodv_s2) begin
				acc_q <= acc_q + {{(mmt_pkg::ACC_W-32){prod_s2[31]}}, prod_s2};
			end
		end
	end

	assign acc = acc_q;

endmodule

/* hw/rtl/modulation_matrix_table_core.sv */
// ----------------------------------------------------------------------------
// modulation_matrix_table_core
// Compacted table of modulation connections with source registers and a
// sequencer that edits entries and sums modulation through one MAC unit.
//
// Add, clear, set source value and any request with a bad index finish
// without raising busy; read, set amount and set active pass S_RWAIT;
// remove walks S_SHRD and S_SHWR, one read and one write per moved entry;
// process makes one table read per entry into the shared MAC, then passes
// S_PDRAIN and S_PFIN. One item at a time; results cannot be stalled.
// Reset clears counts, source-present bits, performance levels and the
// capacity register (to 16); the table itself needs no clearing.
// ----------------------------------------------------------------------------
module modulation_matrix_table_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          req_type,
	input  logic [3:0]          entry_index,
	input  logic [3:0]          source_code,
	input  logic [3:0]          dest_code,
	input  logic signed [15:0]  amount_in,
	input  logic                active_in,
	input  logic signed [15:0]  source_value,
	input  logic signed [31:0]  base_in,
	output logic                done,
	output logic                ok,
	output logic signed [31:0]  modulated_value,
	output logic signed [15:0]  read_amount,
	output logic                read_active,
	output logic [4:0]          entry_count,
	output logic [4:0]          active_count
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = mmt_pkg::CNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RWAIT,
		S_SHRD,
		S_SHWR,
		S_PRUN,
		S_PDRAIN,
		S_PFIN
	} state_t;

	state_t              state_q;
	mmt_pkg::req_t       req_q;
	mmt_pkg::req_t       req_in;
	logic [3:0]          idx_q;
	logic [3:0]          dest_q;
	logic signed [15:0]  amt_q;
	logic                act_q;
	logic signed [31:0]  base_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       stored_q;
	logic [CW-1:0]       enabled_q;
	logic [CW-1:0]       cap_q;
	logic [CW-1:0]       cap_eff;
	logic                v_s1;
	logic                done_q;
	logic                ok_q;
	logic signed [31:0]  modv_q;
	logic signed [15:0]  ramt_q;
	logic                ract_q;

	logic                accept;
	logic                good_in;
	logic                cfg_wr;
	logic                set_ok;
	mmt_pkg::lvl_t       look;
	logic                mac_en;
	logic                mac_clr;
	logic signed [mmt_pkg::ACC_W-1:0] acc;
	logic signed [mmt_pkg::ACC_W-1:0] rnd;
	logic signed [mmt_pkg::ACC_W-1:0] qs;
	logic signed [mmt_pkg::SUM_W-1:0] total;
	logic signed [31:0]  sat;

	mmt_pkg::conn_t      mem [MAX_ENTRIES];
	mmt_pkg::conn_t      rd_q;
	logic                mem_re;
	logic [AW-1:0]       mem_ra;
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	mmt_pkg::conn_t      mem_wd;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign req_in  = mmt_pkg::req_t'(req_type);
	assign cap_eff = (int'(cap_q) < MAX_ENTRIES) ? cap_q : CW'(MAX_ENTRIES);
	assign good_in = ({1'b0, entry_index} < stored_q) && (int'(entry_index) < MAX_ENTRIES);

	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : {{(32-CW){1'b0}}, cap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= mmt_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CW-1:0];
		end
	end

	mmt_sources u_sources (
		.clk      (clk),
		.arst_n   (arst_n),
		.set_en   (accept && (req_in == mmt_pkg::REQ_SETSRC)),
		.set_src  (source_code),
		.set_val  (source_value),
		.set_ok   (set_ok),
		.look_src (rd_q.src),
		.look     (look)
	);

	assign mac_en  = v_s1 && rd_q.active && (rd_q.dest == dest_q) && look.use_it;
	assign mac_clr = accept && (req_in == mmt_pkg::REQ_PROC);

	mmt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mac_clr),
		.en     (mac_en),
		.a      (look.level),
		.b      (rd_q.amount),
		.acc    (acc)
	);

	always_comb begin
		rnd   = acc + mmt_pkg::ROUND_HALF;
		qs    = rnd >>> mmt_pkg::FRAC_BITS;
		total = {{(mmt_pkg::SUM_W-mmt_pkg::ACC_W){qs[mmt_pkg::ACC_W-1]}}, qs}
			+ {{(mmt_pkg::SUM_W-32){base_q[31]}}, base_q};
		if (total > mmt_pkg::SAT_MAX) begin
			sat = mmt_pkg::SAT_MAX[31:0];
		end else if (total < mmt_pkg::SAT_MIN) begin
			sat = mmt_pkg::SAT_MIN[31:0];
		end else begin
			sat = total[31:0];
		end
	end

	always_comb begin
		mem_re = 1'b0;
		mem_ra = AW'(ptr_q);
		mem_we = 1'b0;
		mem_wa = AW'(idx_q);
		mem_wd = rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req_in == mmt_pkg::REQ_ADD) && (stored_q < cap_eff)) begin
					mem_we = 1'b1;
					mem_wa = AW'(stored_q);
					mem_wd = '{src: source_code, dest: dest_code, amount: amount_in,
						active: active_in};
				end else if (accept && good_in && ((req_in == mmt_pkg::REQ_REMOVE)
					|| (req_in == mmt_pkg::REQ_SETAMT) || (req_in == mmt_pkg::REQ_SETACT)
					|| (req_in == mmt_pkg::REQ_READ))) begin
					mem_re = 1'b1;
					mem_ra = AW'(entry_index);
				end
			end
			S_RWAIT: begin
				if (req_q == mmt_pkg::REQ_SETAMT) begin
					mem_we        = 1'b1;
					mem_wd.amount = mmt_pkg::clamp_sym(amt_q);
				end else if (req_q == mmt_pkg::REQ_SETACT) begin
					mem_we        = 1'b1;
					mem_wd.active = act_q;
				end
			end
			S_SHRD: begin
				if ((ptr_q + CW'(1)) < stored_q) begin
					mem_re = 1'b1;
					mem_ra = AW'(ptr_q + CW'(1));
				end
			end
			S_SHWR: begin
				mem_we = 1'b1;
				mem_wa = AW'(ptr_q);
			end
			S_PRUN: begin
				mem_re = (ptr_q < stored_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= mmt_pkg::REQ_ADD;
			idx_q     <= '0;
			dest_q    <= '0;
			amt_q     <= '0;
			act_q     <= 1'b0;
			base_q    <= '0;
			ptr_q     <= '0;
			stored_q  <= '0;
			enabled_q <= '0;
			v_s1      <= 1'b0;
			done_q    <= 1'b0;
			ok_q      <= 1'b0;
			modv_q    <= '0;
			ramt_q    <= '0;
			ract_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q  <= req_in;
						idx_q  <= entry_index;
						dest_q <= dest_code;
						amt_q  <= amount_in;
						act_q  <= active_in;
						base_q <= base_in;
						ok_q   <= 1'b0;
						modv_q <= '0;
						ramt_q <= '0;
						ract_q <= 1'b0;
						unique case (req_in)
							mmt_pkg::REQ_ADD: begin
								if (stored_q < cap_eff) begin
									stored_q  <= stored_q + CW'(1);
									enabled_q <= enabled_q + CW'(active_in);
									ok_q      <= 1'b1;
								end
								done_q <= 1'b1;
							end
							mmt_pkg::REQ_CLEAR: begin
								stored_q  <= '0;
								enabled_q <= '0;
								ok_q      <= 1'b1;
								done_q    <= 1'b1;
							end
							mmt_pkg::REQ_SETSRC: begin
								ok_q   <= set_ok;
								done_q <= 1'b1;
							end
							mmt_pkg::REQ_PROC: begin
								ptr_q   <= '0;
								state_q <= S_PRUN;
							end
							default: begin
								if (good_in) begin
									state_q <= S_RWAIT;
								end else begin
									done_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_RWAIT: begin
					unique case (req_q)
						mmt_pkg::REQ_REMOVE: begin
							if (rd_q.active && (enabled_q != '0)) begin
								enabled_q <= enabled_q - CW'(1);
							end
							ptr_q   <= CW'(idx_q);
							state_q <= S_SHRD;
						end
						mmt_pkg::REQ_SETACT: begin
							if (rd_q.active && !act_q && (enabled_q != '0)) begin
								enabled_q <= enabled_q - CW'(1);
							end else if (!rd_q.active && act_q) begin
								enabled_q <= enabled_q + CW'(1);
							end
							ok_q    <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						mmt_pkg::REQ_READ: begin
							ramt_q  <= rd_q.amount;
							ract_q  <= rd_q.active;
							ok_q    <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						default: begin
							ok_q    <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SHRD: begin
					if ((ptr_q + CW'(1)) < stored_q) begin
						state_q <= S_SHWR;
					end else begin
						stored_q <= stored_q - CW'(1);
						ok_q     <= 1'b1;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SHWR: begin
					ptr_q   <= ptr_q + CW'(1);
					state_q <= S_SHRD;
				end
				S_PRUN: begin
					if (ptr_q < stored_q) begin
						ptr_q <= ptr_q + CW'(1);
						v_s1  <= 1'b1;
					end else begin
						state_q <= S_PDRAIN;
					end
				end
				S_PDRAIN: begin
					state_q <= S_PFIN;
				end
				S_PFIN: begin
					modv_q  <= sat;
					ok_q    <= 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign ok              = ok_q;
	assign modulated_value = modv_q;
	assign read_amount     = ramt_q;
	assign read_active     = ract_q;
	assign entry_count     = stored_q;
	assign active_count    = enabled_q;

endmodule

/* hw/rtl/mmt_checker.sv */
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks on the modulation matrix table: result timing against
// busy and start, and consistency of the result fields.
// ----------------------------------------------------------------------------
module mmt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic                ok,
	input logic signed [31:0]  modulated_value,
	input logic signed [15:0]  read_amount,
	input logic                read_active,
	input logic [4:0]          entry_count,
	input logic [4:0]          active_count
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_busy_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result without an item in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ((modulated_value == 32'sd0) && (read_amount == 16'sd0)
			&& !read_active))
		else $error("failed request carries data");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (active_count <= entry_count))
		else $error("more active entries than stored entries");

endmodule

bind modulation_matrix_table_core mmt_checker u_mmt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.ok              (ok),
	.modulated_value (modulated_value),
	.read_amount     (read_amount),
	.read_active     (read_active),
	.entry_count     (entry_count),
	.active_count    (active_count)
);
